@@ hdl/sboce_pkg.sv @@
package sboce_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned CHAR_W = 7;
    localparam int unsigned SIX_W  = 6;
    localparam int unsigned CARRY_W = 4;

    // Every character has bit 6 set, which moves it into the printable range.
    localparam logic [CHAR_W-1:0] CHAR_TAG = 7'h40;

    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } phase_t;

    typedef struct packed {
        logic [CHAR_W-1:0] code_char;
        logic              run_last;
        logic              message_last;
    } beat_t;

    // The characters that one input byte produces, with a flag for the second one.
    typedef struct packed {
        beat_t first;
        beat_t second;
        logic  two;
    } pair_t;

    function automatic logic [CHAR_W-1:0] tag_char(input logic [SIX_W-1:0] six);
        tag_char = {1'b0, six} | CHAR_TAG;
    endfunction

endpackage

@@ hdl/sboce_in_if.sv @@
interface sboce_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ hdl/sboce_out_if.sv @@
interface sboce_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] code_char;
    logic       run_last;
    logic       message_last;

    modport source (output valid, output code_char, output run_last, output message_last,
                    input ready);
    modport sink (input valid, input code_char, input run_last, input message_last,
                  output ready);
endinterface

@@ hdl/sboce_split.sv @@
module sboce_split
    import sboce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [DATA_W-1:0] data_byte,
    input  logic              last_byte,
    output pair_t             pair
);

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [CARRY_W-1:0]   carry_reg;
    logic [CARRY_W-1:0]   carry_next;

    always_comb
    begin
        pair       = '0;
        phase_next = PH_1;
        carry_next = {2'b00, data_byte[1:0]};
        case (phase_reg)
            PH_1:
            begin
                pair.first.code_char  = tag_char({carry_reg[1:0], data_byte[7:4]});
                pair.first.run_last   = !last_byte;
                pair.second.code_char = tag_char({data_byte[3:0], 2'b00});
                pair.second.run_last  = 1'b1;
                pair.second.message_last = 1'b1;
                pair.two   = last_byte;
                phase_next = PH_2;
                carry_next = data_byte[3:0];
            end
            PH_2:
            begin
                pair.first.code_char  = tag_char({carry_reg, data_byte[7:6]});
                pair.second.code_char = tag_char(data_byte[5:0]);
                pair.second.run_last  = 1'b1;
                pair.second.message_last = last_byte;
                pair.two   = 1'b1;
                phase_next = PH_0;
                carry_next = '0;
            end
            default:
            begin
                pair.first.code_char  = tag_char(data_byte[7:2]);
                pair.first.run_last   = !last_byte;
                pair.second.code_char = tag_char({data_byte[1:0], 4'b0000});
                pair.second.run_last  = 1'b1;
                pair.second.message_last = 1'b1;
                pair.two   = last_byte;
            end
        endcase
        if (last_byte)
        begin
            phase_next = PH_0;
            carry_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_0;
            carry_reg <= '0;
        end
        else if (load)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

`ifndef SYNTHESIS
    // A message end always leaves the encoder at the start of a group.
    assert property (@(posedge clk) disable iff (!rst_n)
        load && last_byte |=> phase_reg == PH_0 && carry_reg == '0)
        else $error("encoder state not cleared after message end");
`endif

endmodule

@@ hdl/sboce_obuf.sv @@
module sboce_obuf
    import sboce_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  pair_t pair,
    output logic  can_load,
    output logic  out_valid,
    input  logic  out_ready,
    output beat_t out_beat
);

    beat_t       slot0_reg;
    beat_t       slot1_reg;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        fire;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_beat  = slot0_reg;
    assign fire      = out_valid && out_ready;
    // A new byte may land while the last pending character leaves.
    assign can_load  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
            cnt_next = pair.two ? 2'd2 : 2'd1;
        else if (fire)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot0_reg <= pair.first;
            slot1_reg <= pair.second;
        end
        else if (fire)
            slot0_reg <= slot1_reg;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("character count out of range");

    // Loading must never overwrite a character that has not yet gone out.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && fire))
        else $error("pending character overwritten");

    // The last character of a message also closes the run of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_beat.message_last |-> out_beat.run_last)
        else $error("message end without run end");
`endif

endmodule

@@ hdl/six_bit_offset_char_encoder.sv @@
// Six-bit offset character encoder. Bytes of a message arrive one per beat on in_ch, with
// last_byte marking the final byte; every three bytes come out on out_ch as four characters,
// each holding six data bits (high bits first) with 0x40 added so that it is printable. A byte
// yields one character, or two in the third position of a group; a final byte in the first or
// second position also flushes the leftover bits as one more zero-padded character, and the
// next message starts a fresh group. run_last marks the last character caused by a byte and
// message_last the last character of the message. All characters leave through the one result
// port, so a byte that yields two characters holds off the next byte until its second
// character is leaving. The first character appears in the cycle after its byte is
// accepted. A new byte is taken in the same cycle as the last pending character leaves,
// so the two sides never wait on each other beyond that.
module six_bit_offset_char_encoder
    import sboce_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    sboce_in_if.sink    in_ch,
    sboce_out_if.source out_ch
);

    logic  load;
    logic  can_load;
    pair_t pair;
    beat_t out_beat;

    assign in_ch.ready = can_load;
    assign load        = in_ch.valid && can_load;

    // Character forming and the group position live in the splitter.
    sboce_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .data_byte (in_ch.data_byte),
        .last_byte (in_ch.last_byte),
        .pair      (pair)
    );

    // The result buffer holds up to two characters and hands them out one per beat.
    sboce_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .pair      (pair),
        .can_load  (can_load),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_beat  (out_beat)
    );

    assign out_ch.code_char    = out_beat.code_char;
    assign out_ch.run_last     = out_beat.run_last;
    assign out_ch.message_last = out_beat.message_last;

endmodule

@@ bench/six_bit_offset_char_encoder_tb.sv @@
module six_bit_offset_char_encoder_tb
    import sboce_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Once fewer than this many bytes are left to send, both sides stop idling.
    localparam int unsigned QUIET_BYTES   = 80;
    localparam int unsigned RANDOM_BYTES  = 700;
    localparam int unsigned MAX_REPORTS   = 100;
    localparam int unsigned DRAIN_CYCLES  = 8;

    // One byte of a message, as it waits to be sent.
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              last_byte;
    } msg_byte_t;

    logic clk;
    logic rst_n;

    sboce_in_if  in_ch ();
    sboce_out_if out_ch ();

    six_bit_offset_char_encoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #10 clk = ~clk;

    // Bytes still to be sent, filled completely before reset is released.
    msg_byte_t pending_bytes[$];
    // Characters that the encoder owes us, oldest first.
    beat_t     owed_chars[$];

    // Our own copy of the encoder state: position within the group of three
    // bytes, and the low bits of the previous byte that are still unsent.
    phase_t             enc_phase;
    logic [CARRY_W-1:0] enc_carry;

    int   error_count;
    int   bytes_taken;
    int   bytes_total;
    int   src_gap;
    int   sink_gap;
    logic quiet_tail;

    initial
    begin
        clk         = 1'b0;
        enc_phase   = PH_0;
        enc_carry   = '0;
        error_count = 0;
        bytes_taken = 0;
        bytes_total = 0;
        src_gap     = 0;
        sink_gap    = 0;
        quiet_tail  = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_REPORTS)
        begin
            $display("%0t ns: %s: got 'h%0h, wanted 'h%0h", $realtime, what, got, want);
        end
        error_count++;
    endtask

    // Builds one character beat: six data bits with the printable tag added.
    function automatic beat_t make_char(input logic [SIX_W-1:0] six, input logic run_end,
                                        input logic msg_end);
        beat_t c;
        c.code_char    = {1'b0, six} | CHAR_TAG;
        c.run_last     = run_end;
        c.message_last = msg_end;
        return c;
    endfunction

    // Works out the characters caused by one accepted byte and queues them,
    // then advances the state. A byte in the third position of a group always
    // gives two characters. In the first or second position it gives one, and
    // a second zero-padded one when it ends the message, to flush the bits
    // that would otherwise wait for the next byte.
    function automatic void encode_byte(input logic [DATA_W-1:0] b, input logic fin);
        case (enc_phase)
            PH_1:
            begin
                owed_chars.push_back(make_char({enc_carry[1:0], b[7:4]}, !fin, 1'b0));
                if (fin)
                begin
                    owed_chars.push_back(make_char({b[3:0], 2'b00}, 1'b1, 1'b1));
                end
                enc_carry = b[3:0];
                enc_phase = PH_2;
            end
            PH_2:
            begin
                owed_chars.push_back(make_char({enc_carry, b[7:6]}, 1'b0, 1'b0));
                owed_chars.push_back(make_char(b[5:0], 1'b1, fin));
                enc_carry = '0;
                enc_phase = PH_0;
            end
            default:
            begin
                owed_chars.push_back(make_char(b[7:2], !fin, 1'b0));
                if (fin)
                begin
                    owed_chars.push_back(make_char({b[1:0], 4'b0000}, 1'b1, 1'b1));
                end
                enc_carry = {2'b00, b[1:0]};
                enc_phase = PH_1;
            end
        endcase
        // Every message starts a fresh group.
        if (fin)
        begin
            enc_phase = PH_0;
            enc_carry = '0;
        end
    endfunction

    task automatic queue_byte(input logic [DATA_W-1:0] b, input logic fin);
        msg_byte_t m;
        m.data_byte = b;
        m.last_byte = fin;
        pending_bytes.push_back(m);
    endtask

    // Source side. A new beat is chosen only when the current one has been
    // taken or none is on offer, so a beat that is held never drops valid.
    // Idle bursts are mixed in until the tail of the run.
    always @(posedge clk)
    begin : byte_driver
        msg_byte_t m;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            quiet_tail <= (pending_bytes.size() < QUIET_BYTES);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (src_gap > 0)
                begin
                    in_ch.valid <= 1'b0;
                    src_gap--;
                end
                else if (!quiet_tail && pending_bytes.size() != 0 &&
                         $urandom_range(0, 4) == 0)
                begin
                    in_ch.valid <= 1'b0;
                    src_gap = $urandom_range(0, 2);
                end
                else if (pending_bytes.size() != 0)
                begin
                    m = pending_bytes.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.data_byte <= m.data_byte;
                    in_ch.last_byte <= m.last_byte;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Sink side: ready drops in random bursts, and stays high once the tail
    // of the run is reached.
    always @(posedge clk)
    begin : char_sink
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            out_ch.ready <= 1'b0;
            sink_gap--;
        end
        else if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            out_ch.ready <= 1'b0;
            sink_gap = $urandom_range(0, 2);
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    // Monitor. Both handshakes are sampled at the clock edge, before any of
    // this edge's updates land. A character beat is checked against the oldest
    // owed character; an accepted byte adds its characters to the queue. The
    // byte count is bumped after the push, so whoever sees the count sees the
    // characters too.
    always @(posedge clk)
    begin : char_monitor
        beat_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (owed_chars.size() == 0)
                begin
                    report_mismatch("character with none owed", out_ch.code_char, 0);
                end
                else
                begin
                    want = owed_chars.pop_front();
                    if (out_ch.code_char !== want.code_char)
                    begin
                        report_mismatch("code_char", out_ch.code_char, want.code_char);
                    end
                    if (out_ch.run_last !== want.run_last)
                    begin
                        report_mismatch("run_last", out_ch.run_last, want.run_last);
                    end
                    if (out_ch.message_last !== want.message_last)
                    begin
                        report_mismatch("message_last", out_ch.message_last,
                                        want.message_last);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                encode_byte(in_ch.data_byte, in_ch.last_byte);
                bytes_taken++;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin : run_control
        int msg_len;
        int i;
        int target;
        logic [DATA_W-1:0] b;

        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        out_ch.ready    = 1'b0;

        // Directed messages. One-byte messages end in the first position of
        // a group, two-byte ones in the second, three-byte ones in the third.
        // The longer ones end in the first and second positions after a full
        // group, so the state is seen to restart after every message.
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hff, 1'b1);
        queue_byte(8'hff, 1'b0);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hff, 1'b1);
        queue_byte(8'hff, 1'b0);
        queue_byte(8'hff, 1'b0);
        queue_byte(8'hff, 1'b1);
        queue_byte(8'ha5, 1'b0);
        queue_byte(8'h5a, 1'b0);
        queue_byte(8'h3c, 1'b0);
        queue_byte(8'hc3, 1'b1);
        queue_byte(8'h81, 1'b0);
        queue_byte(8'h7e, 1'b0);
        queue_byte(8'hff, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h80, 1'b1);

        // Random messages, mostly short so that every end position comes up
        // often, with a few long ones that run through many groups.
        target = pending_bytes.size() + RANDOM_BYTES;
        while (pending_bytes.size() < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                msg_len = $urandom_range(10, 30);
            end
            else
            begin
                msg_len = $urandom_range(1, 6);
            end
            for (i = 0; i < msg_len; i++)
            begin
                case ($urandom_range(0, 9))
                    0:       b = 8'h00;
                    1:       b = 8'hff;
                    default: b = DATA_W'($urandom_range(0, 255));
                endcase
                queue_byte(b, i == msg_len - 1);
            end
        end
        bytes_total = pending_bytes.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Every byte accepted, every owed character seen, then a few more
        // cycles so that a stray extra character would still be caught.
        while (bytes_taken != bytes_total)
        begin
            @(posedge clk);
        end
        while (owed_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // A correct run finishes well before this watchdog fires.
    initial
    begin : watchdog
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
